// File: rtl/swst_pkg.sv
// Package for the sorted wake-up schedule table.
// Holds command codes, time constants and the control word broadcast to every cell.
// No dependencies.
package swst_pkg;

    localparam int KEY_W      = 11;
    localparam int SEC_W      = 17;
    localparam int OP_W       = 2;

    // command codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    localparam int HOUR_MAX     = 23;
    localparam int MINUTE_MAX   = 59;
    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    // control word seen by all cells
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             upd;     // apply add or remove shift this cycle
        logic             load;    // register this cell's delay
        logic             scan;    // advance the running minimum
        logic [KEY_W-1:0] key;     // hour*64 + minute of the time to add
        logic [SEC_W-1:0] now;     // current second, already reduced
    } swst_ctrl_t;

endpackage

// File: rtl/sorted_wakeup_schedule_table.sv
// Sorted wake-up schedule table: top level with control and a row of cells.
// Add, remove and clear pass through EXEC to a registered result; a query
// also runs SCAN and FINAL while the running minimum walks the cell row.
// One word is worked on at a time; a new word is taken while a result waits.
// Reset (synchronous, active low) empties the table; entries keep no reset.
// Depends on swst_pkg and swst_cell.
module sorted_wakeup_schedule_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] mode, [9:2] hour_in, [17:10] minute_in, [25:18] position,
    // [42:26] now_second, [47:43] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [5:1] entry_count, [6] next_found, [23:7] seconds_to_next
    output logic [23:0] m_tdata
);
    import swst_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [SW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [OP_W-1:0]  op_reg;
    logic [7:0]       hour_reg, minute_reg, pos_reg;
    logic [SEC_W-1:0] now_reg;
    logic             m_valid_reg, m_valid_next;
    logic [23:0]      m_data_reg, m_data_next;

    logic [SEC_W-1:0] now_in;
    logic             s_acc, out_free;
    logic             add_ok, rm_ok, dup;
    logic             res_acc, res_found;
    logic [SEC_W-1:0] res_secs;
    swst_ctrl_t       ctrl;

    logic [KEY_W-1:0] key_w   [TABLE_ENTRIES];
    logic             after_w [TABLE_ENTRIES];
    logic             eq_w    [TABLE_ENTRIES];
    logic [SEC_W-1:0] run_w   [TABLE_ENTRIES];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // fold now into one day
    assign now_in = (s_tdata[42:26] >= SEC_W'(SEC_PER_DAY))
                  ? s_tdata[42:26] - SEC_W'(SEC_PER_DAY) : s_tdata[42:26];

    // duplicate check across the row
    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            dup = dup | eq_w[i];
        end
    end

    assign add_ok = (hour_reg <= 8'(HOUR_MAX)) && (minute_reg <= 8'(MINUTE_MAX))
                 && (count_reg < CW'(TABLE_ENTRIES)) && !dup;
    assign rm_ok  = (pos_reg < 8'(count_reg));

    // broadcast control word
    always_comb begin
        ctrl.op   = op_reg;
        ctrl.key  = {hour_reg[4:0], minute_reg[5:0]};
        ctrl.now  = now_reg;
        ctrl.upd  = (state_reg == ST_EXEC) && out_free
                 && (((op_reg == OP_ADD) && add_ok) || ((op_reg == OP_REMOVE) && rm_ok));
        ctrl.load = (state_reg == ST_EXEC) && (op_reg == OP_QUERY);
        ctrl.scan = (state_reg == ST_SCAN);
    end

    // row of cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic [KEY_W-1:0] lk, rk;
        logic             la;
        logic [SEC_W-1:0] rin;
        if (g == 0) begin : g_first
            assign lk  = key_w[g];
            assign la  = 1'b0;
            assign rin = '1;
        end else begin : g_mid
            assign lk  = key_w[g-1];
            assign la  = after_w[g-1];
            assign rin = run_w[g-1];
        end
        if (g == TABLE_ENTRIES - 1) begin : g_last
            assign rk = key_w[g];
        end else begin : g_inner
            assign rk = key_w[g+1];
        end
        swst_cell #(.IDX(g), .CW(CW)) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .pos        (pos_reg),
            .left_key   (lk),
            .left_after (la),
            .right_key  (rk),
            .run_in     (rin),
            .key        (key_w[g]),
            .after      (after_w[g]),
            .eq         (eq_w[g]),
            .run_out    (run_w[g])
        );
    end

    // sequencer and result
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        res_acc       = 1'b0;
        res_found     = 1'b0;
        res_secs      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_QUERY) begin
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end else if (out_free) begin
                    unique case (op_reg)
                        OP_ADD: begin
                            res_acc = add_ok;
                            if (add_ok) count_next = count_reg + 1'b1;
                        end
                        OP_REMOVE: begin
                            res_acc = rm_ok;
                            if (rm_ok) count_next = count_reg - 1'b1;
                        end
                        OP_CLEAR: begin
                            res_acc    = 1'b1;
                            count_next = '0;
                        end
                        OP_QUERY: res_acc = 1'b0;
                        default:  res_acc = 1'b0;
                    endcase
                    m_valid_next = 1'b1;
                    m_data_next  = {res_secs, res_found, 5'(count_next), res_acc};
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SW'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    res_found    = (count_reg != '0);
                    res_acc      = res_found;
                    res_secs     = res_found ? run_w[TABLE_ENTRIES-1] : '0;
                    m_valid_next = 1'b1;
                    m_data_next  = {res_secs, res_found, 5'(count_reg), res_acc};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        scan_cnt_reg <= scan_cnt_next;
        m_data_reg   <= m_data_next;
        if (s_acc) begin
            op_reg     <= s_tdata[1:0];
            hour_reg   <= s_tdata[9:2];
            minute_reg <= s_tdata[17:10];
            pos_reg    <= s_tdata[25:18];
            now_reg    <= now_in;
        end
    end

endmodule

// File: rtl/swst_cell.sv
// One table cell: holds a single sorted entry, shifts with its neighbors,
// and computes its delay and a running minimum handed to the next cell.
// Depends on swst_pkg.
module swst_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                     aclk,
    input  swst_pkg::swst_ctrl_t     ctrl,
    input  logic [CW-1:0]            count,
    input  logic [7:0]               pos,
    input  logic [swst_pkg::KEY_W-1:0] left_key,
    input  logic                     left_after,
    input  logic [swst_pkg::KEY_W-1:0] right_key,
    input  logic [swst_pkg::SEC_W-1:0] run_in,
    output logic [swst_pkg::KEY_W-1:0] key,
    output logic                     after,
    output logic                     eq,
    output logic [swst_pkg::SEC_W-1:0] run_out
);
    import swst_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [SEC_W-1:0] delta_reg, run_reg;
    logic             in_use;
    logic [SEC_W-1:0] target, delta;

    assign in_use = (CW'(IDX) < count);
    assign after  = !in_use || (key_reg > ctrl.key);
    assign eq     = in_use && (key_reg == ctrl.key);
    assign key    = key_reg;
    assign run_out = run_reg;

    // seconds of day for this entry and delay to it (wraps to tomorrow)
    always_comb begin
        target = SEC_W'(key_reg[10:6]) * SEC_W'(SEC_PER_HOUR)
               + SEC_W'(key_reg[5:0]) * SEC_W'(SEC_PER_MIN);
        if (target > ctrl.now) begin
            delta = target - ctrl.now;
        end else begin
            delta = SEC_W'({1'b0, target} + (SEC_W+1)'(SEC_PER_DAY) - {1'b0, ctrl.now});
        end
    end

    // entry shift for insert and remove
    always_comb begin
        key_next = key_reg;
        if (ctrl.upd) begin
            unique case (ctrl.op)
                OP_ADD: begin
                    if (after) begin
                        key_next = left_after ? left_key : ctrl.key;
                    end
                end
                OP_REMOVE: begin
                    if (8'(IDX) >= pos) begin
                        key_next = right_key;
                    end
                end
                OP_CLEAR, OP_QUERY: begin
                    key_next = key_reg;
                end
                default: key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (ctrl.load) begin
            delta_reg <= in_use ? delta : '1;
        end
        if (ctrl.scan) begin
            run_reg <= (delta_reg < run_in) ? delta_reg : run_in;
        end
    end

endmodule
